@@ rtl/assert_macros.svh @@
// Assertion macros shared by the angular order code RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("assertion failed");

`endif

@@ rtl/aoc_pkg.sv @@
// Shared types and constants for the angular order code block
package aoc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int MUL_CHUNK   = 24;
  localparam int PIPE_DEPTH  = 9;

  localparam int LABEL_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CODE_W    = 10;

  localparam logic [LABEL_W-1:0] LABEL_MAX        = 4'd9;
  localparam logic [LABEL_W-1:0] LABEL_REF_RST    = 4'd1;
  localparam logic [LABEL_W-1:0] LABEL_SECOND_RST = 4'd2;
  localparam logic [LABEL_W-1:0] LABEL_THIRD_RST  = 4'd3;

  localparam int DIGIT_HUNDREDS = 100;
  localparam int DIGIT_TENS     = 10;
  localparam int CODE_MAX       = 999;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LABEL_REF    = 2'd0,
    CFG_LABEL_SECOND = 2'd1,
    CFG_LABEL_THIRD  = 2'd2
  } cfg_idx_e;

  // angle quadrant by sign of cosine and sine
  typedef enum logic [1:0] {
    REG_Q1 = 2'd0,
    REG_Q2 = 2'd1,
    REG_Q3 = 2'd2,
    REG_Q4 = 2'd3
  } region_e;

endpackage

@@ rtl/aoc_mul.sv @@
// Two-stage unsigned multiplier built from chunk partial products
module aoc_mul #(
  parameter int AW = 34,
  parameter int BW = 34,
  parameter int CW = aoc_pkg::MUL_CHUNK
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int NA   = (AW + CW - 1) / CW;
  localparam int NB   = (BW + CW - 1) / CW;
  localparam int AEW  = NA * CW;
  localparam int BEW  = NB * CW;
  localparam int SUMW = (NA + NB) * CW;
  localparam int PW   = AW + BW;

  logic [AEW-1:0]    a_ext;
  logic [BEW-1:0]    b_ext;
  logic [2*CW-1:0]   pp_q [NA][NB];
  logic [SUMW-1:0]   sum_d;
  logic [PW-1:0]     p_q;

  assign a_ext = AEW'(a_i);
  assign b_ext = BEW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_ext[i*CW +: CW] * b_ext[j*CW +: CW];
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (SUMW'(pp_q[i][j]) << (CW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d[PW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/aoc_geom.sv @@
// Per-monomer geometry: offsets, products, cross z, dot, norm and quadrant
module aoc_geom #(
  parameter int COORD_WIDTH = aoc_pkg::COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] base_x_i,
  input  logic signed [COORD_WIDTH-1:0] base_y_i,
  input  logic signed [COORD_WIDTH-1:0] base_z_i,
  input  logic signed [COORD_WIDTH-1:0] ref_x_i,
  input  logic signed [COORD_WIDTH-1:0] ref_y_i,
  input  logic signed [COORD_WIDTH-1:0] ref_z_i,
  input  logic signed [COORD_WIDTH-1:0] mono_x_i,
  input  logic signed [COORD_WIDTH-1:0] mono_y_i,
  input  logic signed [COORD_WIDTH-1:0] mono_z_i,
  output aoc_pkg::region_e              region_o,
  output logic [2*COORD_WIDTH+0:0]      cz_abs_o,
  output logic [2*COORD_WIDTH+1:0]      n2_o
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int CZW = PW - 1;

  logic signed [DW-1:0] rx_q, ry_q, rz_q, vx_q, vy_q, vz_q;
  logic signed [PW-1:0] rxvy_q, ryvx_q, rxvx_q, ryvy_q, rzvz_q;
  logic signed [PW-1:0] vxvx_q, vyvy_q, vzvz_q;

  logic signed [PW-1:0] cz;
  logic signed [SW-1:0] dot;
  logic [PW-1:0]        n2_sum;
  logic [PW-1:0]        n2_d;
  logic [CZW-1:0]       cz_abs_d;
  aoc_pkg::region_e     region_d;

  aoc_pkg::region_e     region_q;
  logic [CZW-1:0]       cz_abs_q;
  logic [PW-1:0]        n2_q;

  // stage 1: offsets from the base
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q <= DW'(ref_x_i) - DW'(base_x_i);
      ry_q <= DW'(ref_y_i) - DW'(base_y_i);
      rz_q <= DW'(ref_z_i) - DW'(base_z_i);
      vx_q <= DW'(mono_x_i) - DW'(base_x_i);
      vy_q <= DW'(mono_y_i) - DW'(base_y_i);
      vz_q <= DW'(mono_z_i) - DW'(base_z_i);
    end
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rxvy_q <= rx_q * vy_q;
      ryvx_q <= ry_q * vx_q;
      rxvx_q <= rx_q * vx_q;
      ryvy_q <= ry_q * vy_q;
      rzvz_q <= rz_q * vz_q;
      vxvx_q <= vx_q * vx_q;
      vyvy_q <= vy_q * vy_q;
      vzvz_q <= vz_q * vz_q;
    end
  end

  // stage 3: sine, cosine, norm and quadrant
  always_comb begin
    cz     = rxvy_q - ryvx_q;
    dot    = SW'(rxvx_q) + SW'(ryvy_q) + SW'(rzvz_q);
    n2_sum = $unsigned(vxvx_q) + $unsigned(vyvy_q) + $unsigned(vzvz_q);
    n2_d   = (n2_sum == '0) ? PW'(1) : n2_sum;
    cz_abs_d = cz[PW-1] ? CZW'(-cz) : CZW'(cz);
    case ({dot[SW-1], cz[PW-1]})
      2'b00:   region_d = aoc_pkg::REG_Q1;
      2'b10:   region_d = aoc_pkg::REG_Q2;
      2'b11:   region_d = aoc_pkg::REG_Q3;
      default: region_d = aoc_pkg::REG_Q4;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      region_q <= region_d;
      cz_abs_q <= cz_abs_d;
      n2_q     <= n2_d;
    end
  end

  assign region_o = region_q;
  assign cz_abs_o = cz_abs_q;
  assign n2_o     = n2_q;

endmodule

@@ rtl/aoc_order.sv @@
// Pairwise angle compare, stable ranking and decimal code packing
`include "assert_macros.svh"

module aoc_order #(
  parameter int XW = 100
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic [XW-1:0]                    prod_i [3][3],
  input  aoc_pkg::region_e                 region_i [3],
  input  logic [2:0][aoc_pkg::LABEL_W-1:0] label_i,
  output logic [aoc_pkg::CODE_W-1:0]       code_o
);

  localparam int LW = aoc_pkg::LABEL_W;
  localparam int CODEW = aoc_pkg::CODE_W;

  logic [2:0][2:0]          less_d, less_q;
  logic [2:0][1:0]          rank;
  logic [2:0][2:0]          pos_hit;
  logic [2:0][LW-1:0]       digit;
  logic [CODEW-1:0]         code_d, code_q;
  logic                     odd_quad;
  logic                     ahead;

  // less_d[a][b]: monomer a has a strictly smaller angle than monomer b
  always_comb begin
    less_d   = '0;
    odd_quad = 1'b0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if (a != b) begin
          odd_quad = (region_i[a] == aoc_pkg::REG_Q2) || (region_i[a] == aoc_pkg::REG_Q4);
          if (region_i[a] != region_i[b]) begin
            less_d[a][b] = region_i[a] < region_i[b];
          end else if (odd_quad) begin
            less_d[a][b] = prod_i[a][b] > prod_i[b][a];
          end else begin
            less_d[a][b] = prod_i[a][b] < prod_i[b][a];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      less_q <= less_d;
    end
  end

  // rank = number of monomers placed ahead; ties go by input order
  always_comb begin
    rank    = '0;
    pos_hit = '0;
    digit   = '0;
    ahead   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (j != i) begin
          ahead   = less_q[j][i] || (!less_q[i][j] && (j < i));
          rank[i] = rank[i] + 2'(ahead);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        pos_hit[k][i] = (rank[i] == 2'(k));
        if (pos_hit[k][i]) begin
          digit[k] = digit[k] | label_i[i];
        end
      end
    end
    code_d = CODEW'(digit[0]) * CODEW'(aoc_pkg::DIGIT_HUNDREDS)
           + CODEW'(digit[1]) * CODEW'(aoc_pkg::DIGIT_TENS)
           + CODEW'(digit[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

  `ASSERT_ALWAYS(a_rank_perm, vld_i |-> ($onehot(pos_hit[0]) && $onehot(pos_hit[1])
                                      && $onehot(pos_hit[2])))
  `ASSERT_NEVER(a_less_asym, vld_i && ((less_q[0][1] && less_q[1][0])
                                    || (less_q[0][2] && less_q[2][0])
                                    || (less_q[1][2] && less_q[2][1])))

endmodule

@@ rtl/angular_order_code_top.sv @@
// Angular order code block: top level with pipeline control and label registers
//
// Input channel: in_valid_i / in_stall_o carry one word of base and three
// monomer coordinates (reference, second, third). Output channel:
// out_valid_o / out_stall_i carry order_code_o, the three labels in
// ascending angle order packed as hundreds, tens and units.
// Labels are written through cfg_we_i / cfg_idx_i / cfg_wdata_i (index 0
// reference, 1 second, 2 third); values above nine are stored as nine.
// A word passes from accept to result through geometry, the sine square,
// the cross-multiplied ratios, and compare and packing, in that order.
// One word is accepted every cycle while in_stall_o is low.
// Reset clears all valid bits and loads labels 1, 2 and 3; the pipeline is
// ready right after reset.
// While a result waits under out_stall_i the whole pipeline holds and
// in_stall_o is raised; no word is dropped or repeated.
`include "assert_macros.svh"

module angular_order_code_top #(
  parameter int COORD_WIDTH = aoc_pkg::COORD_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]        base_x_i,
  input  logic signed [COORD_WIDTH-1:0]        base_y_i,
  input  logic signed [COORD_WIDTH-1:0]        base_z_i,
  input  logic signed [COORD_WIDTH-1:0]        ref_x_i,
  input  logic signed [COORD_WIDTH-1:0]        ref_y_i,
  input  logic signed [COORD_WIDTH-1:0]        ref_z_i,
  input  logic signed [COORD_WIDTH-1:0]        second_x_i,
  input  logic signed [COORD_WIDTH-1:0]        second_y_i,
  input  logic signed [COORD_WIDTH-1:0]        second_z_i,
  input  logic signed [COORD_WIDTH-1:0]        third_x_i,
  input  logic signed [COORD_WIDTH-1:0]        third_y_i,
  input  logic signed [COORD_WIDTH-1:0]        third_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [aoc_pkg::CODE_W-1:0]           order_code_o,
  input  logic                                 cfg_we_i,
  input  logic [aoc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [aoc_pkg::LABEL_W-1:0]          cfg_wdata_i
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW;
  localparam int CZW   = PW - 1;
  localparam int CZ2W  = 2 * CZW;
  localparam int XW    = CZ2W + PW;
  localparam int DEPTH = aoc_pkg::PIPE_DEPTH;
  localparam int LW    = aoc_pkg::LABEL_W;

  logic                   en;
  logic [DEPTH-1:0]       valid_q;

  logic [LW-1:0]          label_ref_q, label_second_q, label_third_q;
  logic [LW-1:0]          wval;
  logic [2:0][LW-1:0]     labels;

  logic signed [COORD_WIDTH-1:0] mono_x [3];
  logic signed [COORD_WIDTH-1:0] mono_y [3];
  logic signed [COORD_WIDTH-1:0] mono_z [3];

  aoc_pkg::region_e       region   [3];
  logic [CZW-1:0]         cz_abs   [3];
  logic [PW-1:0]          n2       [3];
  logic [CZ2W-1:0]        cz2      [3];
  logic [PW-1:0]          n2_dly_q [3][2];
  aoc_pkg::region_e       reg_dly_q [3][4];
  aoc_pkg::region_e       region_x [3];
  logic [XW-1:0]          prod     [3][3];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[DEPTH-2:0], in_valid_i};
    end
  end

  assign out_valid_o = valid_q[DEPTH-1];

  // label registers
  assign wval = (cfg_wdata_i > aoc_pkg::LABEL_MAX) ? aoc_pkg::LABEL_MAX : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_ref_q    <= aoc_pkg::LABEL_REF_RST;
      label_second_q <= aoc_pkg::LABEL_SECOND_RST;
      label_third_q  <= aoc_pkg::LABEL_THIRD_RST;
    end else if (cfg_we_i) begin
      case (aoc_pkg::cfg_idx_e'(cfg_idx_i))
        aoc_pkg::CFG_LABEL_REF:    label_ref_q    <= wval;
        aoc_pkg::CFG_LABEL_SECOND: label_second_q <= wval;
        aoc_pkg::CFG_LABEL_THIRD:  label_third_q  <= wval;
        default: ;
      endcase
    end
  end

  assign labels = {label_third_q, label_second_q, label_ref_q};

  assign mono_x[0] = ref_x_i;
  assign mono_y[0] = ref_y_i;
  assign mono_z[0] = ref_z_i;
  assign mono_x[1] = second_x_i;
  assign mono_y[1] = second_y_i;
  assign mono_z[1] = second_z_i;
  assign mono_x[2] = third_x_i;
  assign mono_y[2] = third_y_i;
  assign mono_z[2] = third_z_i;

  for (genvar m = 0; m < 3; m++) begin : g_mono
    aoc_geom #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_geom (
      .clk_i   (clk_i),
      .en_i    (en),
      .base_x_i(base_x_i),
      .base_y_i(base_y_i),
      .base_z_i(base_z_i),
      .ref_x_i (ref_x_i),
      .ref_y_i (ref_y_i),
      .ref_z_i (ref_z_i),
      .mono_x_i(mono_x[m]),
      .mono_y_i(mono_y[m]),
      .mono_z_i(mono_z[m]),
      .region_o(region[m]),
      .cz_abs_o(cz_abs[m]),
      .n2_o    (n2[m])
    );

    aoc_mul #(
      .AW(CZW),
      .BW(CZW),
      .CW(aoc_pkg::MUL_CHUNK)
    ) u_sq (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  (cz_abs[m]),
      .b_i  (cz_abs[m]),
      .p_o  (cz2[m])
    );

    // norm and quadrant follow the multipliers
    always_ff @(posedge clk_i) begin
      if (en) begin
        n2_dly_q[m][0]  <= n2[m];
        n2_dly_q[m][1]  <= n2_dly_q[m][0];
        reg_dly_q[m][0] <= region[m];
        for (int k = 1; k < 4; k++) begin
          reg_dly_q[m][k] <= reg_dly_q[m][k-1];
        end
      end
    end

    assign region_x[m] = reg_dly_q[m][3];
  end

  // prod[a][b] = sin^2 of a times norm^2 of b
  for (genvar a = 0; a < 3; a++) begin : g_row
    for (genvar b = 0; b < 3; b++) begin : g_col
      if (a != b) begin : g_cross
        aoc_mul #(
          .AW(CZ2W),
          .BW(PW),
          .CW(aoc_pkg::MUL_CHUNK)
        ) u_cross (
          .clk_i(clk_i),
          .en_i (en),
          .a_i  (cz2[a]),
          .b_i  (n2_dly_q[b][1]),
          .p_o  (prod[a][b])
        );
      end else begin : g_diag
        assign prod[a][b] = '0;
      end
    end
  end

  aoc_order #(
    .XW(XW)
  ) u_order (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (valid_q[DEPTH-2]),
    .prod_i  (prod),
    .region_i(region_x),
    .label_i (labels),
    .code_o  (order_code_o)
  );

  `ASSERT_ALWAYS(a_label_range, (label_ref_q <= aoc_pkg::LABEL_MAX)
                               && (label_second_q <= aoc_pkg::LABEL_MAX)
                               && (label_third_q <= aoc_pkg::LABEL_MAX))
  `ASSERT_ALWAYS(a_code_range, out_valid_o |-> (order_code_o <= aoc_pkg::CODE_W'(aoc_pkg::CODE_MAX)))
  `ASSERT_ALWAYS(a_stall_hold, (out_valid_o && out_stall_i) |=> $stable(valid_q))

endmodule

@@ verif/tb_angular_order_code_top.sv @@
// Testbench for angular_order_code_top: random and directed geometry words checked against a predictor
module tb_angular_order_code_top;

  localparam int NUM_COORDS   = 12;
  localparam int NUM_PHASES   = 7;
  localparam int PHASE_WORDS  = 158;
  localparam int LIMIT_TIME   = 1000000;

  typedef logic signed [aoc_pkg::COORD_WIDTH-1:0] coord_t;
  // 0..2 base, 3..5 reference, 6..8 second, 9..11 third (x, y, z each)
  typedef coord_t [NUM_COORDS-1:0] geom_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  coord_t base_x_i = '0, base_y_i = '0, base_z_i = '0;
  coord_t ref_x_i = '0, ref_y_i = '0, ref_z_i = '0;
  coord_t second_x_i = '0, second_y_i = '0, second_z_i = '0;
  coord_t third_x_i = '0, third_y_i = '0, third_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [aoc_pkg::CODE_W-1:0] order_code_o;
  logic cfg_we_i = 1'b0;
  logic [aoc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [aoc_pkg::LABEL_W-1:0] cfg_wdata_i = '0;

  logic [aoc_pkg::LABEL_W-1:0] label_m [3] = '{aoc_pkg::LABEL_REF_RST,
                                               aoc_pkg::LABEL_SECOND_RST,
                                               aoc_pkg::LABEL_THIRD_RST};

  geom_word_t pending_words[$];
  logic [aoc_pkg::CODE_W-1:0] expected_codes[$];
  geom_word_t cur_word;
  logic [aoc_pkg::CODE_W-1:0] exp_code;
  int words_queued = 0;
  int words_accepted = 0;
  int errors = 0;
  int in_gap = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  angular_order_code_top #(.COORD_WIDTH(aoc_pkg::COORD_WIDTH)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .base_x_i(base_x_i), .base_y_i(base_y_i), .base_z_i(base_z_i),
    .ref_x_i(ref_x_i), .ref_y_i(ref_y_i), .ref_z_i(ref_z_i),
    .second_x_i(second_x_i), .second_y_i(second_y_i), .second_z_i(second_z_i),
    .third_x_i(third_x_i), .third_y_i(third_y_i), .third_z_i(third_z_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .order_code_o(order_code_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [aoc_pkg::CODE_W-1:0] predict_order_code(geom_word_t w);
    longint px[3], py[3], pz[3];
    longint cz, dot, nsq, czm;
    aoc_pkg::region_e quad[3];
    logic [127:0] sin_sq[3], len_sq[3];
    logic [127:0] lhs, rhs;
    int ord[3];
    int i, j, k, tmp, code;
    bit earlier, settled;
    for (i = 0; i < 3; i++) begin
      px[i] = longint'($signed(w[3 + 3 * i])) - longint'($signed(w[0]));
      py[i] = longint'($signed(w[4 + 3 * i])) - longint'($signed(w[1]));
      pz[i] = longint'($signed(w[5 + 3 * i])) - longint'($signed(w[2]));
    end
    for (i = 0; i < 3; i++) begin
      cz  = px[0] * py[i] - py[0] * px[i];
      dot = px[0] * px[i] + py[0] * py[i] + pz[0] * pz[i];
      nsq = px[i] * px[i] + py[i] * py[i] + pz[i] * pz[i];
      if (nsq == 0) nsq = 1;
      czm = (cz < 0) ? -cz : cz;
      sin_sq[i] = 128'(czm) * 128'(czm);
      len_sq[i] = 128'(nsq);
      if (dot >= 0 && cz >= 0) quad[i] = aoc_pkg::REG_Q1;
      else if (cz >= 0) quad[i] = aoc_pkg::REG_Q2;
      else if (dot < 0) quad[i] = aoc_pkg::REG_Q3;
      else quad[i] = aoc_pkg::REG_Q4;
      ord[i] = i;
    end
    // stable insertion sort by angle
    for (i = 1; i < 3; i++) begin
      tmp = ord[i];
      j = i;
      settled = 1'b0;
      while (j > 0 && !settled) begin
        k = ord[j - 1];
        if (quad[tmp] != quad[k]) begin
          earlier = quad[tmp] < quad[k];
        end else begin
          lhs = sin_sq[tmp] * len_sq[k];
          rhs = sin_sq[k] * len_sq[tmp];
          earlier = (quad[tmp] == aoc_pkg::REG_Q1 || quad[tmp] == aoc_pkg::REG_Q3)
                    ? (lhs < rhs) : (lhs > rhs);
        end
        if (earlier) begin
          ord[j] = k;
          j--;
        end else begin
          settled = 1'b1;
        end
      end
      ord[j] = tmp;
    end
    code = label_m[ord[0]] * aoc_pkg::DIGIT_HUNDREDS + label_m[ord[1]] * aoc_pkg::DIGIT_TENS
         + label_m[ord[2]];
    return aoc_pkg::CODE_W'(code);
  endfunction

  function automatic geom_word_t mk(int bx, int by, int bz, int rx, int ry, int rz,
                                    int sx, int sy, int sz, int tx, int ty, int tz);
    geom_word_t w;
    w[0] = coord_t'(bx);  w[1] = coord_t'(by);  w[2] = coord_t'(bz);
    w[3] = coord_t'(rx);  w[4] = coord_t'(ry);  w[5] = coord_t'(rz);
    w[6] = coord_t'(sx);  w[7] = coord_t'(sy);  w[8] = coord_t'(sz);
    w[9] = coord_t'(tx);  w[10] = coord_t'(ty); w[11] = coord_t'(tz);
    return w;
  endfunction

  function automatic geom_word_t random_word();
    geom_word_t w;
    int mode, k;
    mode = $urandom_range(0, 9);
    for (k = 0; k < NUM_COORDS; k++) w[k] = coord_t'($urandom);
    if (mode >= 5 && mode <= 7) begin
      // tight cluster around the base: ties, zero vectors, all quadrants
      for (k = 3; k < NUM_COORDS; k++) w[k] = w[k % 3] + coord_t'($urandom_range(0, 8) - 4);
    end else if (mode == 8) begin
      for (k = 0; k < NUM_COORDS; k++) begin
        case ($urandom_range(0, 4))
          0: w[k] = 16'sh8000;
          1: w[k] = 16'sh7FFF;
          2: w[k] = '0;
          3: w[k] = '1;
          default: ;
        endcase
      end
    end else if (mode == 9) begin
      for (k = 0; k < 3; k++) begin
        case ($urandom_range(0, 3))
          0: w[3 + k] = w[k];
          1: w[9 + k] = w[6 + k];
          2: w[6 + k] = w[k] + w[k] - w[3 + k];
          default: w[9 + k] = w[k];
        endcase
      end
    end
    return w;
  endfunction

  task automatic write_label(aoc_pkg::cfg_idx_e idx, logic [aoc_pkg::LABEL_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    label_m[idx] = (val > aoc_pkg::LABEL_MAX) ? aoc_pkg::LABEL_MAX : val;
  endtask

  task automatic queue_word(geom_word_t w);
    pending_words = {pending_words, w};
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || expected_codes.size() != 0) @(posedge clk_i);
    repeat (aoc_pkg::PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_codes = {expected_codes, predict_order_code(cur_word)};
        words_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          base_x_i   <= cur_word[0];  base_y_i   <= cur_word[1];  base_z_i   <= cur_word[2];
          ref_x_i    <= cur_word[3];  ref_y_i    <= cur_word[4];  ref_z_i    <= cur_word[5];
          second_x_i <= cur_word[6];  second_y_i <= cur_word[7];  second_z_i <= cur_word[8];
          third_x_i  <= cur_word[9];  third_y_i  <= cur_word[10]; third_z_i  <= cur_word[11];
          in_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 15);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall generator
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_codes.size() == 0) begin
          $error("order_code: no word expected, actual %0d", order_code_o);
          errors++;
        end else begin
          exp_code = expected_codes.pop_front();
          if (order_code_o !== exp_code) begin
            $error("order_code: expected %0d, actual %0d", exp_code, order_code_o);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int ph, n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words, reset labels
    queue_word(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_word(mk(5, 5, 5, 5, 5, 5, 9, -3, 2, -7, 4, 1));          // reference on base
    queue_word(mk(0, 0, 0, 1, 0, 0, 0, 0, 0, -1, -1, 0));          // second on base
    queue_word(mk(0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1, 0));            // sine and cosine zero
    queue_word(mk(0, 0, 0, 1, 0, 0, 2, 2, 0, 1, 1, 0));            // equal angles
    queue_word(mk(0, 0, 0, 1, 0, 0, 1, -1, 0, -1, 1, 0));
    queue_word(mk(0, 0, 0, 1, 0, 0, -1, -1, 0, -1, 1, 0));
    queue_word(mk(0, 0, 0, 1, 0, 0, 1, 2, 0, 2, 1, 0));
    queue_word(mk(0, 0, 0, 1, 0, 0, -1, 2, 0, -2, 1, 0));
    queue_word(mk(0, 0, 0, 1, 0, 0, -1, -2, 0, -2, -1, 0));
    queue_word(mk(0, 0, 0, 1, 0, 0, 1, -2, 0, 2, -1, 0));
    queue_word(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                  32767, -32768, 32767, -32768, 32767, -32768));
    queue_word(mk(32767, 32767, 32767, -32768, -32768, -32768,
                  -32768, 32767, 0, 32767, -32768, 32767));
    queue_word(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                  32767, 32767, 32767, 32767, 32767, 32767));
    queue_word(mk(10, 10, 0, 13, 14, 0, 7, 6, 0, 12, 9, 0));        // opposite direction
    queue_word(mk(0, 0, 0, 0, 0, 5, 3, 4, -2, -3, 1, 7));           // reference along z
    queue_word(mk(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                  16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555));
    queue_word(mk(-1, -1, -1, 40, -1, -1, -30, 20, 9, 40, -1, -1)); // third equals reference
    wait_drained();

    for (ph = 1; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      case (ph)
        1: begin
          write_label(aoc_pkg::CFG_LABEL_REF, 4'd9);
          write_label(aoc_pkg::CFG_LABEL_SECOND, 4'd0);
          write_label(aoc_pkg::CFG_LABEL_THIRD, 4'd5);
        end
        2: begin
          write_label(aoc_pkg::CFG_LABEL_REF, 4'd0);
          write_label(aoc_pkg::CFG_LABEL_SECOND, 4'd9);
          write_label(aoc_pkg::CFG_LABEL_THIRD, 4'd4);
        end
        3: begin
          write_label(aoc_pkg::CFG_LABEL_REF, 4'd15);
          write_label(aoc_pkg::CFG_LABEL_SECOND, 4'd10);
          write_label(aoc_pkg::CFG_LABEL_THIRD, 4'd12);
        end
        5: begin
          write_label(aoc_pkg::CFG_LABEL_REF, 4'd6);
          write_label(aoc_pkg::CFG_LABEL_SECOND, 4'd3);
          write_label(aoc_pkg::CFG_LABEL_THIRD, 4'd8);
        end
        default: begin
          write_label(aoc_pkg::CFG_LABEL_REF, aoc_pkg::LABEL_W'($urandom_range(0, 15)));
          write_label(aoc_pkg::CFG_LABEL_SECOND, aoc_pkg::LABEL_W'($urandom_range(0, 15)));
          write_label(aoc_pkg::CFG_LABEL_THIRD, aoc_pkg::LABEL_W'($urandom_range(0, 15)));
        end
      endcase
      cfg_we_i <= 1'b0;
      for (n = 0; n < PHASE_WORDS; n++) queue_word(random_word());
      wait_drained();
    end

    if (errors == 0 && expected_codes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
